FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the scan range median filter.
// No dependencies; SYNTH selects the empty forms for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that an implication holds on every clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

FILE: rtl/srmf_pkg.sv
// Types and constants of the scan range median filter.
// No dependencies; imported by every other RTL file of the block but assert_macros.svh.
package srmf_pkg;

  localparam int RANGE_W = 15;
  localparam int RAW_W = 16;
  localparam int IDX_W = 12;
  // Cells of history ahead of the newest sample (window of five)
  localparam int HIST_LEN = 4;
  localparam int WIN_LEN = HIST_LEN + 1;
  // Cell that holds the centre of the window
  localparam int CENTRE_TAP = 2;
  localparam int MEDIAN_RANK = 2;
  // Sample count saturates here (scan of up to 4096 samples)
  localparam logic [IDX_W-1:0] COUNT_CAP = 12'd4095;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = 15'd10000;

  typedef logic [RANGE_W-1:0] range_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

FILE: rtl/srmf_if.sv
// Handshake channels of the scan range median filter: samples in, results out.
// Depends on srmf_pkg.
interface srmf_in_if
  import srmf_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [RAW_W-1:0]  range_raw;
  logic                     no_return;
  logic                     scan_end;

  modport source (output valid, range_raw, no_return, scan_end, input ready);
  modport sink (input valid, range_raw, no_return, scan_end, output ready);
endinterface

interface srmf_out_if
  import srmf_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] filtered_range;
  logic               centre_invalid;
  logic [IDX_W-1:0]   centre_index;
  logic               last_of_scan;

  modport source (output valid, filtered_range, centre_invalid, centre_index,
                  last_of_scan, input ready);
  modport sink (input valid, filtered_range, centre_invalid, centre_index,
                last_of_scan, output ready);
endinterface

FILE: rtl/srmf_cell.sv
// One window cell: holds a sample value and its validity, takes its neighbor's.
// Depends on srmf_pkg.
module srmf_cell
  import srmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  range_t     d_value,
  input  logic       d_valid,
  output range_t     q_value,
  output logic       q_valid
);

  range_t value;
  logic   valid;

  // Clear at scan end, otherwise advance from the neighbor on each item
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      if (ctrl.clear) begin
        value <= '0;
        valid <= 1'b0;
      end else begin
        value <= d_value;
        valid <= d_valid;
      end
    end
  end

  assign q_value = value;
  assign q_valid = valid;

endmodule

FILE: rtl/srmf_median.sv
// Median of five ranges by rank counting: twenty compares in parallel, one select.
// Depends on srmf_pkg.
module srmf_median
  import srmf_pkg::*;
(
  input  range_t win [WIN_LEN],
  output range_t med
);

  logic [2:0] rank [WIN_LEN];

  // Rank each element; ties go to the lower position first
  always_comb begin
    for (int i = 0; i < WIN_LEN; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WIN_LEN; j++) begin
        if (j != i) begin
          if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
            rank[i] = rank[i] + 3'd1;
          end
        end
      end
    end
  end

  // Pick the element of middle rank (exactly one has it)
  always_comb begin
    med = '0;
    for (int i = 0; i < WIN_LEN; i++) begin
      if (rank[i] == 3'(MEDIAN_RANK)) begin
        med = win[i];
      end
    end
  end

endmodule

FILE: rtl/scan_range_median_filter.sv
// Top level of the scan range median filter: window cells, median, output stage.
// Depends on srmf_pkg, srmf_if, srmf_cell, srmf_median and assert_macros.svh.
//
//  channel   dir  payload                                              handshake
//  samples   in   range_raw, no_return, scan_end                       valid/ready
//  results   out  filtered_range, centre_invalid, centre_index, last   valid/ready
//  cfg       in   cfg_wr_data (max_range)                              cfg_wr_en
//
// One sample per cycle while samples are being taken; a result appears in the cycle after the sample that
// completes its window, held in the single output register.
// Samples are taken while the output register is empty or being drained.
// Reset empties the window, zeroes the count and loads max_range = 10000.
`include "assert_macros.svh"

module scan_range_median_filter
  import srmf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  range_t       cfg_wr_data,
  srmf_in_if.sink      samples,
  srmf_out_if.source   results
);

  range_t           max_range;
  logic [IDX_W-1:0] sample_count;
  logic             accept;
  logic             in_valid;
  range_t           in_value;
  cell_ctrl_t       ctrl;
  range_t           cell_value [HIST_LEN];
  logic             cell_valid [HIST_LEN];
  range_t           win [WIN_LEN];
  range_t           med;
  range_t           result;
  logic             window_full;

  logic             out_valid;
  range_t           out_range;
  logic             out_inv;
  logic [IDX_W-1:0] out_index;
  logic             out_last;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_range <= MAX_RANGE_RESET;
    end else if (cfg_wr_en) begin
      max_range <= cfg_wr_data;
    end
  end

  assign samples.ready = !out_valid || results.ready;
  assign accept = samples.valid && samples.ready;

  // Classify the new sample; replace invalid ones by the marker
  assign in_valid = !samples.no_return && !samples.range_raw[RAW_W-1] &&
                    (samples.range_raw[RANGE_W-1:0] <= max_range);
  assign in_value = in_valid ? samples.range_raw[RANGE_W-1:0] : max_range;

  assign ctrl.shift = accept;
  assign ctrl.clear = samples.scan_end;

  // Row of history cells, oldest at index zero
  for (genvar k = 0; k < HIST_LEN; k++) begin : g_cell
    range_t d_value;
    logic   d_valid;
    if (k == HIST_LEN - 1) begin : g_tail
      assign d_value = in_value;
      assign d_valid = in_valid;
    end else begin : g_mid
      assign d_value = cell_value[k+1];
      assign d_valid = cell_valid[k+1];
    end
    srmf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .d_value (d_value),
      .d_valid (d_valid),
      .q_value (cell_value[k]),
      .q_valid (cell_valid[k])
    );
    assign win[k] = cell_value[k];
  end
  assign win[HIST_LEN] = in_value;

  srmf_median u_median (
    .win (win),
    .med (med)
  );

  // Choose marker, centre or median
  always_comb begin
    if (!cell_valid[CENTRE_TAP]) begin
      result = max_range;
    end else if (med == max_range) begin
      result = cell_value[CENTRE_TAP];
    end else begin
      result = med;
    end
  end

  assign window_full = (sample_count >= IDX_W'(HIST_LEN));

  // Count samples of the scan; saturate, drop to zero at scan end
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (accept) begin
      if (samples.scan_end) begin
        sample_count <= '0;
      end else if (sample_count < COUNT_CAP) begin
        sample_count <= sample_count + 1'b1;
      end
    end
  end

  // Output register: load on a completing item, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && window_full) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && window_full) begin
      out_range <= result;
      out_inv   <= !cell_valid[CENTRE_TAP];
      out_index <= sample_count - IDX_W'(CENTRE_TAP);
      out_last  <= samples.scan_end;
    end
  end

  assign results.valid          = out_valid;
  assign results.filtered_range = out_range;
  assign results.centre_invalid = out_inv;
  assign results.centre_index   = out_index;
  assign results.last_of_scan   = out_last;

  `ASSERT_IMPLY(a_result_follows, clk, rst, accept && window_full |=> results.valid, "completing item gave no result")
  `ASSERT_IMPLY(a_scan_end_clears, clk, rst, accept && samples.scan_end |=> (sample_count == '0) && !cell_valid[HIST_LEN-1], "scan end left state behind")
  `ASSERT_IMPLY(a_count_steps, clk, rst, accept && !samples.scan_end && (sample_count < COUNT_CAP) |=> sample_count == $past(sample_count) + 1'b1, "sample count did not advance")
  `ASSERT_NEVER(a_no_early_take, clk, rst, accept && !window_full && out_valid && !results.ready, "item taken while result stalled")

endmodule

FILE: tb/range_median_tracker.sv
`timescale 1ns / 1ps
// Scoreboard for the scan range median filter: predicts one result per centre sample.
// Depends on srmf_pkg for the reset value of max_range and the sample count cap.
class range_median_tracker;

  typedef struct packed {
    logic [14:0] filt;
    logic        inv;
    logic [11:0] idx;
    logic        last;
  } median_result_t;

  bit [14:0]      max_range;
  bit [15:0]      hist_val [4];
  bit             hist_ok [4];
  bit [11:0]      count;
  median_result_t expected_q [$];
  int             errors;

  function new();
    max_range = srmf_pkg::MAX_RANGE_RESET;
    clear_window();
    errors = 0;
  endfunction

  // Empty the history and restart the scan count
  function void clear_window();
    foreach (hist_val[i]) begin
      hist_val[i] = '0;
      hist_ok[i] = 1'b0;
    end
    count = '0;
  endfunction

  function void set_max_range(bit [14:0] v);
    max_range = v;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Note one accepted sample and queue the result it completes, if any
  function void take_sample(bit [15:0] raw, bit no_ret, bit last);
    bit             ok;
    bit [15:0]      val;
    bit [15:0]      marker;
    bit [15:0]      win [$];
    median_result_t r;
    marker = {1'b0, max_range};
    ok = !no_ret && !raw[15] && (raw <= marker);
    val = ok ? raw : marker;
    if (count >= 12'd4) begin
      win = '{hist_val[0], hist_val[1], hist_val[2], hist_val[3], val};
      win.sort();
      r.inv = !hist_ok[2];
      // Invalid centre gives the marker; a median equal to the marker falls back to the centre
      if (r.inv) begin
        r.filt = max_range;
      end else if (win[2] == marker) begin
        r.filt = hist_val[2][14:0];
      end else begin
        r.filt = win[2][14:0];
      end
      r.idx = count - 12'd2;
      r.last = last;
      expected_q.insert(expected_q.size(), r);
    end
    if (last) begin
      clear_window();
    end else begin
      for (int k = 0; k < 3; k++) begin
        hist_val[k] = hist_val[k + 1];
        hist_ok[k] = hist_ok[k + 1];
      end
      hist_val[3] = val;
      hist_ok[3] = ok;
      if (count < srmf_pkg::COUNT_CAP) count = count + 12'd1;
    end
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // Compare one accepted result with the oldest prediction
  task match_result(logic [14:0] filt, logic inv, logic [11:0] idx, logic last);
    median_result_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("result with nothing predicted: filt=%0d idx=%0d", filt, idx));
      return;
    end
    e = expected_q[0];
    expected_q.delete(0);
    if (filt !== e.filt)
      report($sformatf("idx %0d filtered_range got %0d want %0d", e.idx, filt, e.filt));
    if (inv !== e.inv)
      report($sformatf("idx %0d centre_invalid got %b want %b", e.idx, inv, e.inv));
    if (idx !== e.idx)
      report($sformatf("centre_index got %0d want %0d", idx, e.idx));
    if (last !== e.last)
      report($sformatf("idx %0d last_of_scan got %b want %b", e.idx, last, e.last));
  endtask

endclass

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench for the scan range median filter: clock, reset, drivers, checks.
// Depends on srmf_pkg, srmf_if, the filter RTL and range_median_tracker.
module testbench;
  import srmf_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_SCAN = 100;
  localparam int RANDOM_ITEMS = 570;
  localparam int PHASES = 10;

  logic   clk;
  logic   rst;
  logic   cfg_wr_en;
  range_t cfg_wr_data;

  srmf_in_if  samples ();
  srmf_out_if results ();

  scan_range_median_filter dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .samples     (samples),
    .results     (results)
  );

  range_median_tracker tracker = new();

  bit     no_idle = 1'b0;
  range_t cur_max = MAX_RANGE_RESET;
  int     scan_left = 0;
  int     cycles = 0;
  bit     result_taken;
  int     ready_hold;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      tracker.match_result(results.filtered_range, results.centre_invalid,
                           results.centre_index, results.last_of_scan);
      result_taken = 1'b1;
    end
  end

  // Stall the result side for a random number of cycles after each item
  always @(negedge clk) begin
    if (result_taken) begin
      result_taken = 1'b0;
      ready_hold = no_idle ? 0 : $urandom_range(0, 18);
    end
    if (ready_hold > 0) begin
      results.ready <= 1'b0;
      ready_hold--;
    end else begin
      results.ready <= 1'b1;
    end
  end

  // Drop valid; leaves the caller at a falling edge
  task automatic stop_sending();
    @(negedge clk);
    samples.valid <= 1'b0;
  endtask

  // Offer one sample after a random gap and hold it until taken
  task automatic send_sample(logic [15:0] raw, logic nr, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples.valid <= 1'b1;
    samples.range_raw <= raw;
    samples.no_return <= nr;
    samples.scan_end <= last;
    do @(posedge clk); while (!samples.ready);
    tracker.take_sample(raw, nr, last);
  endtask

  // Wait until every predicted result is in, then let the pipeline settle
  task automatic drain();
    stop_sending();
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_range(range_t v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    tracker.set_max_range(v);
    cur_max = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Draw a range: mostly valid, with marker hits, overshoots, negatives and raw noise
  function automatic logic [15:0] pick_range();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 16'($urandom_range(0, cur_max));
    if (r < 63) return {1'b0, cur_max};
    if (r < 68) return 16'($urandom_range(0, 3));
    if (r < 76) begin
      if (cur_max == 15'h7FFF) return {1'b0, cur_max};
      return 16'($urandom_range(cur_max + 1, 32767));
    end
    if (r < 84) return {1'b1, 15'($urandom)};
    return 16'($urandom);
  endfunction

  // Send random samples grouped into scans, mostly long enough to filter
  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      if (scan_left == 0)
        scan_left = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      send_sample(pick_range(), $urandom_range(0, 9) == 0, scan_left == 1);
      scan_left--;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    samples.valid = 1'b0;
    samples.range_raw = '0;
    samples.no_return = 1'b0;
    samples.scan_end = 1'b0;
    results.ready = 1'b0;
    result_taken = 1'b0;
    ready_hold = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Edge values, negative, overshoot, marker and no-return at the reset marker
    send_sample(16'd100, 1'b0, 1'b0);
    send_sample(16'd200, 1'b0, 1'b0);
    send_sample(16'hFFFF, 1'b0, 1'b0);
    send_sample(16'd10001, 1'b0, 1'b0);
    send_sample(16'd10000, 1'b0, 1'b0);
    send_sample(16'd50, 1'b1, 1'b0);
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(16'h7FFF, 1'b0, 1'b0);
    send_sample(16'h8000, 1'b0, 1'b0);
    send_sample(16'd300, 1'b0, 1'b1);
    // Valid centre among invalid neighbours: median hits the marker
    send_sample(16'd1, 1'b1, 1'b0);
    send_sample(16'd2, 1'b1, 1'b0);
    send_sample(16'd500, 1'b0, 1'b0);
    send_sample(16'd3, 1'b1, 1'b0);
    send_sample(16'd10000, 1'b0, 1'b1);
    // Short scans give no result
    send_sample(16'd7, 1'b0, 1'b0);
    send_sample(16'd8, 1'b0, 1'b1);
    send_sample(16'd9, 1'b0, 1'b1);
    // Zero marker
    write_max_range(15'd0);
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(16'd1, 1'b0, 1'b0);
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(16'h7FFF, 1'b0, 1'b0);
    send_sample(16'd0, 1'b0, 1'b1);
    // Full-scale marker, then change it in the middle of a scan
    write_max_range(15'h7FFF);
    send_sample(16'h7FFF, 1'b0, 1'b0);
    send_sample(16'h8000, 1'b0, 1'b0);
    send_sample(16'd32000, 1'b0, 1'b0);
    write_max_range(15'd20);
    send_sample(16'd25, 1'b0, 1'b0);
    send_sample(16'd5, 1'b0, 1'b1);

    // Long scan sent back to back, without gaps
    write_max_range(MAX_RANGE_RESET);
    no_idle = 1'b1;
    for (int i = 0; i < LONG_SCAN; i++)
      send_sample(pick_range(), $urandom_range(0, 9) == 0, i == LONG_SCAN - 1);
    no_idle = 1'b0;

    // Random phases; each marker write usually lands inside an open scan
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_max_range(15'h7FFF);
        1: write_max_range(15'd0);
        2: write_max_range(MAX_RANGE_RESET);
        3: write_max_range(range_t'($urandom_range(0, 40)));
        default: write_max_range(range_t'($urandom_range(0, 32767)));
      endcase
      no_idle = (p % 4 == 3);
      send_random(RANDOM_ITEMS / PHASES);
    end
    no_idle = 1'b0;

    drain();
    repeat (10) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/srmf_pkg.sv
rtl/srmf_if.sv
rtl/srmf_cell.sv
rtl/srmf_median.sv
rtl/scan_range_median_filter.sv
tb/range_median_tracker.sv
tb/testbench.sv
